### design/rmul_pkg.sv
package rmul_pkg;

    // Widths of the divisor and of the length counter.
    localparam int VALUE_BITS = 20;
    localparam int COUNT_BITS = 24;

    // Decimal radix used by the remainder recurrence.
    localparam int RADIX     = 10;
    localparam int DIGIT_MAX = RADIX - 1;

    // A value of 10*r + 1 with r below the divisor needs four more bits.
    localparam int WIDE_BITS = VALUE_BITS + 4;

    // Hex digits of the divisor. Used by the divisible-by-five test.
    localparam int NIBBLES = (VALUE_BITS + 3) / 4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // take a new divisor and build its multiples
        logic init;     // remainder = 1 mod d, count = 1
        logic step;     // remainder = (10*remainder + 1) mod d, count + 1
        logic capture;  // copy the finished result to the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic invalid;   // divisor is zero, even or a multiple of five
        logic rem_zero;  // running remainder is zero
    } t_status;

    // Divisible by five: since 16 is 1 mod 5, the sum of the hex digits keeps
    // the value mod 5. Three folds bring any sum down to at most 15.
    function automatic logic is_mult5(input logic [VALUE_BITS-1:0] v);
        logic [NIBBLES*4-1:0] w;
        logic [7:0]           s;
        w = (NIBBLES*4)'(v);
        s = '0;
        for (int i = 0; i < NIBBLES; i++) begin
            s = s + 8'(w[i*4 +: 4]);
        end
        for (int j = 0; j < 3; j++) begin
            s = 8'(s[7:4]) + 8'(s[3:0]);
        end
        return (s == 8'd0) || (s == 8'd5) || (s == 8'd10) || (s == 8'd15);
    endfunction

endpackage

### design/repunit_multiple_length_unit.sv
// Smallest repunit multiple length unit.
//
// The input channel (i_divisor_valid / o_divisor_ready) carries one 20-bit
// unsigned divisor per transaction. The output channel (o_result_valid /
// i_result_ready) returns one transaction per divisor: o_status is 0 when a
// repunit multiple exists and 1 for a zero, even or multiple-of-five divisor,
// and o_ones_count gives the number of ones digits (0 when invalid).
// The block works on one divisor at a time. After acceptance it checks the
// divisor, applies remainder updates until the remainder is zero, and then
// loads the output register; an invalid divisor goes from the check straight
// to loading the output register. The next divisor is taken once the
// controller is back in idle. The search loop runs on the single remainder
// update unit, which forms 10*r + 1 and reduces it by the largest fitting
// multiple of the divisor. N never exceeds the divisor. A finished result
// sits in an output register, so a stalled receiver does not hold up the
// next divisor: it is accepted and searched while the previous result
// waits, and only its hand-off waits for the register to drain. Reset is
// synchronous and active low; it empties the output register and returns
// the controller to idle.
module repunit_multiple_length_unit
    import rmul_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_divisor_valid,
    output logic                  o_divisor_ready,
    input  logic [VALUE_BITS-1:0] i_divisor,
    output logic                  o_result_valid,
    input  logic                  i_result_ready,
    output logic                  o_status,
    output logic [COUNT_BITS-1:0] o_ones_count
);

    t_cmd    cmd;
    t_status status;

    // The controller sequences load, check, search and hand-off.
    rmul_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_divisor_valid),
        .o_in_ready  (o_divisor_ready),
        .o_out_valid (o_result_valid),
        .i_out_ready (i_result_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath holds the divisor, its multiples, the running remainder,
    // the digit count and the output register.
    rmul_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_divisor    (i_divisor),
        .o_status     (status),
        .o_res_status (o_status),
        .o_res_count  (o_ones_count)
    );

endmodule

### design/rmul_datapath.sv
module rmul_datapath
    import rmul_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [VALUE_BITS-1:0] i_divisor,
    output t_status               o_status,
    output logic                  o_res_status,
    output logic [COUNT_BITS-1:0] o_res_count
);

    logic [VALUE_BITS-1:0] r_div;
    logic [WIDE_BITS-1:0]  r_mult [1:DIGIT_MAX];
    logic [VALUE_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_cnt;
    logic                  r_res_status;
    logic [COUNT_BITS-1:0] r_res_count;

    logic [VALUE_BITS-1:0] n_rem;
    logic [WIDE_BITS-1:0]  wide;
    logic [WIDE_BITS-1:0]  sel_sub;
    logic [WIDE_BITS-1:0]  diff;
    logic                  invalid;

    assign invalid = (r_div == '0) || !r_div[0] || is_mult5(r_div);

    // One remainder update: form 10*r + 1, find the largest multiple k*d not
    // above it by parallel compares, and subtract it.
    always_comb begin
        wide    = (WIDE_BITS'(r_rem) << 3) + (WIDE_BITS'(r_rem) << 1) + WIDE_BITS'(1);
        sel_sub = '0;
        for (int k = 1; k <= DIGIT_MAX; k++) begin
            if (wide >= r_mult[k]) begin
                sel_sub = r_mult[k];
            end
        end
        diff  = wide - sel_sub;
        n_rem = diff[VALUE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_div <= i_divisor;
            for (int k = 1; k <= DIGIT_MAX; k++) begin
                r_mult[k] <= WIDE_BITS'(i_divisor) * WIDE_BITS'(k);
            end
        end
        if (i_cmd.init) begin
            r_rem <= (r_div == VALUE_BITS'(1)) ? '0 : VALUE_BITS'(1);
            r_cnt <= COUNT_BITS'(1);
        end else if (i_cmd.step) begin
            r_rem <= n_rem;
            r_cnt <= r_cnt + COUNT_BITS'(1);
        end
        if (i_cmd.capture) begin
            r_res_status <= invalid;
            r_res_count  <= invalid ? '0 : r_cnt;
        end
    end

    assign o_status.invalid  = invalid;
    assign o_status.rem_zero = (r_rem == '0);
    assign o_res_status      = r_res_status;
    assign o_res_count       = r_res_count;

    // The remainder always stays below the divisor after an update.
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (r_rem < r_div))
        else $error("remainder not reduced below divisor");

    // Each update adds exactly one digit to the count.
    a_cnt_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !i_cmd.init) |=> (r_cnt == $past(r_cnt) + COUNT_BITS'(1)))
        else $error("digit count did not advance by one");

    // A found result always has a nonzero length.
    a_found_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.capture |=> (r_res_status || (r_res_count != '0)))
        else $error("found result with zero length");

endmodule

### design/rmul_ctrl.sv
module rmul_ctrl
    import rmul_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RUN,
        ST_FINISH
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   slot_free;

    // The output register can take a result when empty or being emptied.
    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE:   o_cmd.load    = i_in_valid;
            ST_CHECK:  o_cmd.init    = !i_status.invalid;
            ST_RUN:    o_cmd.step    = !i_status.rem_zero;
            ST_FINISH: o_cmd.capture = slot_free;
            default:   o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // A new result takes the slot as the old one leaves it.
            if (r_state == ST_FINISH && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    r_state <= i_status.invalid ? ST_FINISH : ST_RUN;
                end
                ST_RUN: begin
                    if (i_status.rem_zero) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (slot_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

    // An accepted transaction always moves on to the divisor check.
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_CHECK))
        else $error("accepted transaction did not start a check");

    // A captured result is presented on the next cycle.
    a_capture_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_out_valid)
        else $error("captured result not presented");

endmodule
